// File: hdl/weighted_jacobi_stencil_sweep_macros.svh
// Assertion macros for the stencil sweep modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef WEIGHTED_JACOBI_STENCIL_SWEEP_MACROS_SVH
`define WEIGHTED_JACOBI_STENCIL_SWEEP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define JWS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");
`define JWS_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("implication violated");
`else
`define JWS_ASSERT(lbl, cond)
`define JWS_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// File: hdl/jws_pkg.sv
package jws_pkg;

	localparam int POS_OUT_BITS = 10;
	localparam int RELAX_BITS = 15;
	localparam int GRID_BITS = 11;
	localparam int CFG_DATA_BITS = 15;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [CFG_INDEX_BITS-1:0] REG_RELAX = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GRID = 1'b1;

	localparam logic [RELAX_BITS-1:0] RELAX_RESET = 15'd14746;
	localparam logic [GRID_BITS-1:0] GRID_RESET = 11'd1024;
	localparam int GRID_MIN = 4;

	localparam int MQ_DEPTH = 4;
	localparam int MQ_CW = $clog2(MQ_DEPTH + 1);
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);
	localparam int MUL_SHIFT = 16;

	typedef struct packed {
		logic a_v;
		logic a_border;
		logic b_v;
		logic c_v;
		logic [POS_OUT_BITS-1:0] row;
		logic [POS_OUT_BITS-1:0] col;
	} jws_ctl_t;

endpackage

// File: hdl/weighted_jacobi_stencil_sweep.sv
// Channel   Direction  Handshake     Payload
// input     in         push / full   cell_value, frame_start
// result    out        pop / empty   out_value, out_row, out_col, last
// config    in         wr_en         wr_index, wr_data
//
// One item can be accepted every cycle; full rises when the four-entry queue behind the
// classifier, counting the item being classified, has no free slot left.
// Results leave one per cycle, while pop is high, from an eight-entry output queue;
// an item with two or three results takes that many entries of that queue.
// Each result passes the classifier register, the queue, s1 to s3 and the output queue.
// Reset clears counters, window registers and queues, sets config, not the line buffer.
module weighted_jacobi_stencil_sweep #(
	parameter int MAX_GRID = 1024,
	parameter int CELL_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [CELL_BITS-1:0]          cell_value,
	input  logic                                 frame_start,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [CELL_BITS-1:0]          out_value,
	output logic [jws_pkg::POS_OUT_BITS-1:0]     out_row,
	output logic [jws_pkg::POS_OUT_BITS-1:0]     out_col,
	output logic                                 last,
	input  logic                                 wr_en,
	input  logic [jws_pkg::CFG_INDEX_BITS-1:0]   wr_index,
	input  logic [jws_pkg::CFG_DATA_BITS-1:0]    wr_data
);
	import jws_pkg::*;

	localparam int MQW = $bits(jws_ctl_t) + 6 * CELL_BITS;

	logic [RELAX_BITS-1:0] relax_q;
	logic [GRID_BITS-1:0] grid_q;
	logic mq_push;
	logic mq_pop;
	logic [MQW-1:0] mq_din;
	logic [MQW-1:0] mq_dout;
	logic [MQ_CW-1:0] mq_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= RELAX_RESET;
			grid_q <= GRID_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RELAX: relax_q <= wr_data[RELAX_BITS-1:0];
				REG_GRID: grid_q <= wr_data[GRID_BITS-1:0];
				default: ;
			endcase
		end
	end

	jws_front #(
		.MAX_GRID(MAX_GRID),
		.CELL_BITS(CELL_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cell_value(cell_value),
		.frame_start(frame_start),
		.grid_size(grid_q),
		.mq_count(mq_count),
		.mq_push(mq_push),
		.mq_din(mq_din)
	);

	jws_fifo #(
		.WIDTH(MQW),
		.DEPTH(MQ_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(mq_push),
		.din(mq_din),
		.pop(mq_pop),
		.dout(mq_dout),
		.count(mq_count)
	);

	jws_back #(
		.CELL_BITS(CELL_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.relax_factor(relax_q),
		.mq_count(mq_count),
		.mq_dout(mq_dout),
		.mq_pop(mq_pop),
		.empty(empty),
		.pop(pop),
		.out_value(out_value),
		.out_row(out_row),
		.out_col(out_col),
		.last(last)
	);
endmodule

// File: hdl/jws_fifo.sv
`include "weighted_jacobi_stencil_sweep_macros.svh"

module jws_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : AW'(rd_ptr_q + 1'b1);
			end
			count_q <= CW'(count_q + CW'(push) - CW'(pop));
		end
	end

	assign dout = mem_q[rd_ptr_q];
	assign count = count_q;

	`JWS_ASSERT_IMP(a_no_underflow, pop, count_q != '0)
endmodule

// File: hdl/jws_front.sv
`include "weighted_jacobi_stencil_sweep_macros.svh"

module jws_front #(
	parameter int MAX_GRID = 1024,
	parameter int CELL_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [CELL_BITS-1:0]       cell_value,
	input  logic                              frame_start,
	input  logic [jws_pkg::GRID_BITS-1:0]     grid_size,
	input  logic [jws_pkg::MQ_CW-1:0]         mq_count,
	output logic                              mq_push,
	output logic [$bits(jws_pkg::jws_ctl_t)+6*CELL_BITS-1:0] mq_din
);
	import jws_pkg::*;

	localparam int PW = $clog2(MAX_GRID);
	localparam int NW = PW + 1;
	localparam int CB = CELL_BITS;

	logic [NW-1:0] n;
	logic accept;
	logic restart;
	logic [PW-1:0] r;
	logic [PW-1:0] c;
	logic [NW-1:0] c_inc;
	logic [NW-1:0] r_inc;
	logic [PW-1:0] row_d;
	logic [PW-1:0] col_d;

	logic [PW-1:0] row_q;
	logic [PW-1:0] col_q;

	logic v_s1;
	logic fwd_s1;
	logic signed [CB-1:0] bot_s1;
	logic [PW-1:0] addr_s1;
	logic r_ge1_s1;
	logic c_ge1_s1;
	logic r_is1_s1;
	logic c_is1_s1;
	logic c_last_s1;
	logic r_last_s1;
	logic [POS_OUT_BITS-1:0] row_s1;
	logic [POS_OUT_BITS-1:0] col_s1;
	logic [2*CB-1:0] rd_s1;

	logic [2*CB-1:0] lb_mem [MAX_GRID];
	logic signed [CB-1:0] win_q [6];

	logic signed [CB-1:0] top;
	logic signed [CB-1:0] mid;
	jws_ctl_t ctl;

	always_comb begin
		if (int'(grid_size) < GRID_MIN) begin
			n = NW'(GRID_MIN);
		end else if (int'(grid_size) > MAX_GRID) begin
			n = NW'(MAX_GRID);
		end else begin
			n = NW'(grid_size);
		end
	end

	assign full = (int'(mq_count) + int'(v_s1)) >= MQ_DEPTH;
	assign accept = push && !full;

	assign restart = frame_start || (NW'(row_q) >= n) || (NW'(col_q) >= n);
	assign r = restart ? '0 : row_q;
	assign c = restart ? '0 : col_q;
	assign c_inc = NW'(c) + 1'b1;
	assign r_inc = NW'(r) + 1'b1;

	always_comb begin
		if (c_inc >= n) begin
			col_d = '0;
			row_d = (r_inc >= n) ? '0 : PW'(r_inc);
		end else begin
			col_d = PW'(c_inc);
			row_d = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			v_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			fwd_s1 <= accept && v_s1 && (c == addr_s1);
			if (accept) begin
				row_q <= row_d;
				col_q <= col_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bot_s1 <= cell_value;
			addr_s1 <= c;
			r_ge1_s1 <= r != '0;
			c_ge1_s1 <= c != '0;
			r_is1_s1 <= r == PW'(1);
			c_is1_s1 <= c == PW'(1);
			c_last_s1 <= NW'(c) == NW'(n - 1'b1);
			r_last_s1 <= NW'(r) == NW'(n - 1'b1);
			row_s1 <= POS_OUT_BITS'(r);
			col_s1 <= POS_OUT_BITS'(c);
		end
	end

	// Line buffer entry holds {row r-2, row r-1} for its column.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			lb_mem[addr_s1] <= {mid, bot_s1};
		end
		if (accept) begin
			rd_s1 <= lb_mem[c];
		end
	end

	// When the previous item wrote the same column in the cycle of this read,
	// its values are still in the window registers.
	assign top = fwd_s1 ? win_q[1] : rd_s1[2*CB-1:CB];
	assign mid = fwd_s1 ? win_q[2] : rd_s1[CB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top;
			win_q[1] <= mid;
			win_q[2] <= bot_s1;
		end
	end

	always_comb begin
		ctl.a_v = r_ge1_s1 && c_ge1_s1;
		ctl.a_border = r_is1_s1 || c_is1_s1;
		ctl.b_v = r_ge1_s1 && c_last_s1;
		ctl.c_v = r_last_s1;
		ctl.row = row_s1;
		ctl.col = col_s1;
	end

	assign mq_push = v_s1 && (ctl.a_v || ctl.b_v || ctl.c_v);
	assign mq_din = {ctl, win_q[1], win_q[0], win_q[2], win_q[4], mid, bot_s1};

	`JWS_ASSERT_IMP(a_push_has_room, mq_push, int'(mq_count) < MQ_DEPTH)
endmodule

// File: hdl/jws_back.sv
`include "weighted_jacobi_stencil_sweep_macros.svh"

module jws_back #(
	parameter int CELL_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [jws_pkg::RELAX_BITS-1:0]     relax_factor,
	input  logic [jws_pkg::MQ_CW-1:0]          mq_count,
	input  logic [$bits(jws_pkg::jws_ctl_t)+6*CELL_BITS-1:0] mq_dout,
	output logic                               mq_pop,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [CELL_BITS-1:0]        out_value,
	output logic [jws_pkg::POS_OUT_BITS-1:0]   out_row,
	output logic [jws_pkg::POS_OUT_BITS-1:0]   out_col,
	output logic                               last
);
	import jws_pkg::*;

	localparam int CB = CELL_BITS;
	localparam int SW = CB + 1;
	localparam int DW = CB + 3;
	localparam int MW = DW + MUL_SHIFT;
	localparam int RW = CB + 4;

	jws_ctl_t h_ctl;
	logic signed [CB-1:0] h_s;
	logic signed [CB-1:0] h_up;
	logic signed [CB-1:0] h_dn;
	logic signed [CB-1:0] h_lf;
	logic signed [CB-1:0] h_rt;
	logic signed [CB-1:0] h_bot;
	logic [OQ_CW-1:0] nres_h;
	logic pop_acc;

	logic [OQ_CW-1:0] committed_q;
	logic [OQ_CW-1:0] oq_count_q;
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;

	logic v_s1, v_s2, v_s3;
	jws_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic signed [CB-1:0] s_s1, s_s2, s_s3;
	logic signed [CB-1:0] rt_s1, rt_s2, rt_s3;
	logic signed [CB-1:0] bot_s1, bot_s2, bot_s3;
	logic signed [SW-1:0] sud_s1;
	logic signed [SW-1:0] slr_s1;
	logic signed [DW-1:0] d_s2;
	logic signed [MW-1:0] prod_s3;

	logic signed [DW-1:0] q;
	logic signed [RW-1:0] diff;
	logic ovf;
	logic signed [CB-1:0] sat;
	logic signed [CB-1:0] a_val;
	logic [OQ_CW-1:0] nw;
	logic [OQ_AW-1:0] idx_b;
	logic [OQ_AW-1:0] idx_c;
	logic [POS_OUT_BITS-1:0] row_m1;
	logic [POS_OUT_BITS-1:0] col_m1;

	logic signed [CB-1:0] oq_val [OQ_DEPTH];
	logic [POS_OUT_BITS-1:0] oq_row [OQ_DEPTH];
	logic [POS_OUT_BITS-1:0] oq_col [OQ_DEPTH];
	logic oq_last [OQ_DEPTH];

	assign {h_ctl, h_s, h_up, h_dn, h_lf, h_rt, h_bot} = mq_dout;
	assign nres_h = OQ_CW'(h_ctl.a_v) + OQ_CW'(h_ctl.b_v) + OQ_CW'(h_ctl.c_v);

	// Every result taken from the queue has a reserved output slot.
	assign mq_pop = (mq_count != '0) && (int'(committed_q) + int'(nres_h) <= OQ_DEPTH);
	assign pop_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= mq_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= h_ctl;
		s_s1 <= h_s;
		rt_s1 <= h_rt;
		bot_s1 <= h_bot;
		sud_s1 <= SW'(h_up) + SW'(h_dn);
		slr_s1 <= SW'(h_lf) + SW'(h_rt);

		ctl_s2 <= ctl_s1;
		s_s2 <= s_s1;
		rt_s2 <= rt_s1;
		bot_s2 <= bot_s1;
		d_s2 <= (DW'(s_s1) <<< 2) - (DW'(sud_s1) + DW'(slr_s1));

		ctl_s3 <= ctl_s2;
		s_s3 <= s_s2;
		rt_s3 <= rt_s2;
		bot_s3 <= bot_s2;
		prod_s3 <= MW'(d_s2) * MW'($signed({1'b0, relax_factor}));
	end

	// The arithmetic shift rounds the exact product toward minus infinity.
	assign q = prod_s3[MW-1:MUL_SHIFT];
	assign diff = RW'(s_s3) - RW'(q);
	assign ovf = !((&diff[RW-1:CB-1]) || !(|diff[RW-1:CB-1]));

	always_comb begin
		if (ovf) begin
			sat = diff[RW-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
		end else begin
			sat = diff[CB-1:0];
		end
	end

	assign a_val = ctl_s3.a_border ? s_s3 : sat;
	assign nw = v_s3 ? (OQ_CW'(ctl_s3.a_v) + OQ_CW'(ctl_s3.b_v) + OQ_CW'(ctl_s3.c_v)) : '0;
	assign idx_b = OQ_AW'(wr_ptr_q + OQ_AW'(ctl_s3.a_v));
	assign idx_c = OQ_AW'(idx_b + OQ_AW'(ctl_s3.b_v));
	assign row_m1 = ctl_s3.row - 1'b1;
	assign col_m1 = ctl_s3.col - 1'b1;

	always_ff @(posedge clk) begin
		if (v_s3 && ctl_s3.a_v) begin
			oq_val[wr_ptr_q] <= a_val;
			oq_row[wr_ptr_q] <= row_m1;
			oq_col[wr_ptr_q] <= col_m1;
			oq_last[wr_ptr_q] <= !ctl_s3.b_v && !ctl_s3.c_v;
		end
		if (v_s3 && ctl_s3.b_v) begin
			oq_val[idx_b] <= rt_s3;
			oq_row[idx_b] <= row_m1;
			oq_col[idx_b] <= ctl_s3.col;
			oq_last[idx_b] <= !ctl_s3.c_v;
		end
		if (v_s3 && ctl_s3.c_v) begin
			oq_val[idx_c] <= bot_s3;
			oq_row[idx_c] <= ctl_s3.row;
			oq_col[idx_c] <= ctl_s3.col;
			oq_last[idx_c] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q <= '0;
			oq_count_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			committed_q <= OQ_CW'(committed_q + (mq_pop ? nres_h : '0) - OQ_CW'(pop_acc));
			oq_count_q <= OQ_CW'(oq_count_q + nw - OQ_CW'(pop_acc));
			wr_ptr_q <= OQ_AW'(wr_ptr_q + OQ_AW'(nw));
			if (pop_acc) begin
				rd_ptr_q <= OQ_AW'(rd_ptr_q + 1'b1);
			end
		end
	end

	assign empty = oq_count_q == '0;
	assign out_value = oq_val[rd_ptr_q];
	assign out_row = oq_row[rd_ptr_q];
	assign out_col = oq_col[rd_ptr_q];
	assign last = oq_last[rd_ptr_q];

	`JWS_ASSERT(a_credit_bound, int'(committed_q) <= OQ_DEPTH)
	`JWS_ASSERT(a_count_within_credit, oq_count_q <= committed_q)
endmodule
